@@ hw/rtl/ultrasonic_echo_ranger_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define UER_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define UER_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/uer_pkg.sv @@
`default_nettype none

package uer_pkg;

    localparam int TICK_W     = 20;
    localparam int TRIG_W     = 8;
    localparam int UPC_W      = 8;
    localparam int DIST_W     = 16;
    localparam int DIVD_W     = TICK_W + 4;
    localparam int DIV_CNT_W  = $clog2(DIVD_W);
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [TRIG_W-1:0] RST_TRIG_WIDTH = 8'd10;
    localparam logic [TICK_W-1:0] RST_TIMEOUT    = 20'd100000;
    localparam logic [UPC_W-1:0]  RST_US_PER_CM  = 8'd50;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TRIG_WIDTH = 2'd0,
        REG_TIMEOUT    = 2'd1,
        REG_US_PER_CM  = 2'd2
    } t_reg_addr;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_RISE  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_BUSY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } t_phase;

    typedef enum logic {
        SQ_TAKE = 1'b0,
        SQ_DIV  = 1'b1
    } t_seq;

endpackage

`default_nettype wire

@@ hw/rtl/uer_ifs.sv @@
`default_nettype none

interface uer_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_out_if;
    logic                        valid;
    logic                        ready;
    logic                        trigger_level;
    logic                        busy_res;
    logic                        done_res;
    logic [1:0]                  status;
    logic [uer_pkg::TICK_W-1:0]  echo_time_us;
    logic [uer_pkg::DIST_W-1:0]  distance;

    modport source (output valid, output trigger_level, output busy_res, output done_res,
                    output status, output echo_time_us, output distance, input ready);
    modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                    input status, input echo_time_us, input distance, output ready);
endinterface

interface uer_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [uer_pkg::CFG_ADDR_W-1:0]  addr;
    logic [uer_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
`default_nettype none

// Ultrasonic echo ranger: each input transfer is one microsecond tick carrying a start
// request and the sampled echo level, and each yields exactly one output transfer. A start
// gives one trigger-low tick, then trigger_width_us ticks with the trigger high (zero acts
// as one), then a wait for the echo to rise and a measurement of its high width, both
// bounded by timeout_us. An echo fall reports the width and the distance in 1/16 cm,
// floor(width*16/us_per_cm), saturated to 65535 (also for us_per_cm of zero). A start
// while busy is refused with status busy unless the measurement ends on that tick.
// Rate: a tick that does not end a measurement successfully is registered straight into the
// output, and the next tick is taken in the following cycle as long as the output register
// drains. A tick that ends with status ok runs the distance through a bit-serial divider, one
// quotient bit per cycle over a 24-bit dividend, and no further tick is taken until that
// result appears in the output register. Configuration writes are always accepted and should
// only be made while no tick is outstanding.
module ultrasonic_echo_ranger (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    uer_in_if.sink     i_in,
    uer_out_if.source  o_out,
    uer_cfg_if.sink    i_cfg
);

    // configuration registers
    logic [uer_pkg::TRIG_W-1:0]  r_trig_width, n_trig_width;
    logic [uer_pkg::TICK_W-1:0]  r_timeout, n_timeout;
    logic [uer_pkg::UPC_W-1:0]   r_us_per_cm, n_us_per_cm;

    // measurement state
    uer_pkg::t_phase             r_phase, n_phase;
    logic [uer_pkg::TICK_W-1:0]  r_tick, n_tick;

    // sequencer
    uer_pkg::t_seq               r_seq, n_seq;

    // output register
    logic                        r_out_vld, n_out_vld;
    logic                        r_trig, n_trig;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    uer_pkg::t_status            r_status, n_status;
    logic [uer_pkg::TICK_W-1:0]  r_etime, n_etime;
    logic [uer_pkg::DIST_W-1:0]  r_dist, n_dist;

    // tick step results
    logic                        s_trig;
    logic                        s_done;
    uer_pkg::t_status            s_status;
    logic [uer_pkg::TICK_W-1:0]  s_etime;
    logic                        s_need_div;
    uer_pkg::t_phase             s_phase;
    logic [uer_pkg::TICK_W-1:0]  s_tick;
    logic [uer_pkg::TICK_W-1:0]  w_inc;

    logic                        w_in_acc;
    logic                        w_cfg_acc;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [uer_pkg::DIST_W-1:0]  w_div_quot;

    // ------------------------------------------------------------------
    // Configuration port: always ready, decode the index, ignore unknown ones
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;

    always_comb begin
        n_trig_width = r_trig_width;
        n_timeout    = r_timeout;
        n_us_per_cm  = r_us_per_cm;
        if (w_cfg_acc) begin
            unique case (i_cfg.addr)
                uer_pkg::REG_TRIG_WIDTH: n_trig_width = i_cfg.data[uer_pkg::TRIG_W-1:0];
                uer_pkg::REG_TIMEOUT:    n_timeout    = i_cfg.data[uer_pkg::TICK_W-1:0];
                uer_pkg::REG_US_PER_CM:  n_us_per_cm  = i_cfg.data[uer_pkg::UPC_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // One tick of the ranging phase machine
    // ------------------------------------------------------------------
    assign w_inc = r_tick + 1'b1;

    always_comb begin
        s_trig     = 1'b0;
        s_done     = 1'b0;
        s_status   = uer_pkg::ST_OK;
        s_etime    = '0;
        s_need_div = 1'b0;
        s_phase    = r_phase;
        s_tick     = r_tick;

        unique case (r_phase)
            uer_pkg::PH_IDLE: begin
                // the start tick itself is the trigger-low tick
                if (i_in.start_req) begin
                    s_phase = uer_pkg::PH_TRIG;
                    s_tick  = '0;
                end
            end
            uer_pkg::PH_TRIG: begin
                s_trig = 1'b1;
                s_tick = w_inc;
                if (w_inc >= {{(uer_pkg::TICK_W-uer_pkg::TRIG_W){1'b0}}, r_trig_width}) begin
                    s_phase = uer_pkg::PH_WAIT;
                    s_tick  = '0;
                end
            end
            uer_pkg::PH_WAIT: begin
                if (i_in.echo_level) begin
                    s_phase = uer_pkg::PH_MEAS;
                    s_tick  = '0;
                end else begin
                    s_tick = w_inc;
                    if (w_inc >= r_timeout) begin
                        s_done   = 1'b1;
                        s_status = uer_pkg::ST_NO_RISE;
                        s_etime  = w_inc;
                        s_phase  = uer_pkg::PH_IDLE;
                        s_tick   = '0;
                    end
                end
            end
            uer_pkg::PH_MEAS: begin
                if (!i_in.echo_level) begin
                    // echo fell: report the width, distance follows from the divider
                    s_done     = 1'b1;
                    s_status   = uer_pkg::ST_OK;
                    s_etime    = r_tick;
                    s_need_div = 1'b1;
                    s_phase    = uer_pkg::PH_IDLE;
                    s_tick     = '0;
                end else begin
                    s_tick = w_inc;
                    if (w_inc >= r_timeout) begin
                        s_done   = 1'b1;
                        s_status = uer_pkg::ST_TOO_LONG;
                        s_etime  = w_inc;
                        s_phase  = uer_pkg::PH_IDLE;
                        s_tick   = '0;
                    end
                end
            end
            default: ;
        endcase

        // refuse a start while busy; an end on the same tick wins
        if ((r_phase != uer_pkg::PH_IDLE) && i_in.start_req && !s_done) begin
            s_done   = 1'b1;
            s_status = uer_pkg::ST_BUSY;
            s_etime  = '0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: take ticks, park in SQ_DIV while the divider runs
    // ------------------------------------------------------------------
    assign i_in.ready  = (r_seq == uer_pkg::SQ_TAKE) && (!r_out_vld || o_out.ready);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_div_start = w_in_acc && s_need_div;

    always_comb begin
        n_seq     = r_seq;
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_out_vld = r_out_vld;
        n_trig    = r_trig;
        n_busy    = r_busy;
        n_done    = r_done;
        n_status  = r_status;
        n_etime   = r_etime;
        n_dist    = r_dist;

        // drop the held result once its transfer completes
        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_seq)
            uer_pkg::SQ_TAKE: begin
                if (w_in_acc) begin
                    n_phase  = s_phase;
                    n_tick   = s_tick;
                    n_trig   = s_trig;
                    n_busy   = s_phase != uer_pkg::PH_IDLE;
                    n_done   = s_done;
                    n_status = s_status;
                    n_etime  = s_etime;
                    n_dist   = '0;
                    if (s_need_div) begin
                        n_seq = uer_pkg::SQ_DIV;
                    end else begin
                        n_out_vld = 1'b1;
                    end
                end
            end
            uer_pkg::SQ_DIV: begin
                // output register is empty here: it was drained when the tick was taken
                if (w_div_done) begin
                    n_dist    = w_div_quot;
                    n_out_vld = 1'b1;
                    n_seq     = uer_pkg::SQ_TAKE;
                end
            end
            default: n_seq = uer_pkg::SQ_TAKE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_width <= uer_pkg::RST_TRIG_WIDTH;
            r_timeout    <= uer_pkg::RST_TIMEOUT;
            r_us_per_cm  <= uer_pkg::RST_US_PER_CM;
            r_phase      <= uer_pkg::PH_IDLE;
            r_tick       <= '0;
            r_seq        <= uer_pkg::SQ_TAKE;
            r_out_vld    <= 1'b0;
        end else begin
            r_trig_width <= n_trig_width;
            r_timeout    <= n_timeout;
            r_us_per_cm  <= n_us_per_cm;
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_seq        <= n_seq;
            r_out_vld    <= n_out_vld;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_trig   <= n_trig;
        r_busy   <= n_busy;
        r_done   <= n_done;
        r_status <= n_status;
        r_etime  <= n_etime;
        r_dist   <= n_dist;
    end

    // ------------------------------------------------------------------
    // Serial divider: width * 16 / us_per_cm
    // ------------------------------------------------------------------
    uer_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({r_tick, 4'b0000}),
        .i_divisor  (r_us_per_cm),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    assign o_out.valid         = r_out_vld;
    assign o_out.trigger_level = r_trig;
    assign o_out.busy_res      = r_busy;
    assign o_out.done_res      = r_done;
    assign o_out.status        = r_status;
    assign o_out.echo_time_us  = r_etime;
    assign o_out.distance      = r_dist;

endmodule

`default_nettype wire

@@ hw/rtl/uer_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle; quotient saturates to DIST_W bits.
module uer_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [uer_pkg::DIVD_W-1:0]  i_dividend,
    input  wire logic [uer_pkg::UPC_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [uer_pkg::DIST_W-1:0]       o_quot
);

    localparam logic [uer_pkg::DIV_CNT_W-1:0] LAST_STEP =
        uer_pkg::DIV_CNT_W'(uer_pkg::DIVD_W - 1);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [uer_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [uer_pkg::UPC_W-1:0]       r_rem, n_rem;
    logic [uer_pkg::DIVD_W-1:0]      r_quo, n_quo;
    logic [uer_pkg::UPC_W-1:0]       r_divisor, n_divisor;

    logic [uer_pkg::UPC_W:0]         w_shift;
    logic [uer_pkg::UPC_W:0]         w_diff;
    logic                            w_qbit;

    always_comb begin
        // a zero divisor gives all ones, which saturates like an overflow
        w_shift = {r_rem, r_quo[uer_pkg::DIVD_W-1]};
        w_diff  = w_shift - {1'b0, r_divisor};
        w_qbit  = w_shift >= {1'b0, r_divisor};

        n_busy    = r_busy;
        n_done    = 1'b0;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_divisor = r_divisor;

        if (i_start) begin
            n_busy    = 1'b1;
            n_cnt     = '0;
            n_rem     = '0;
            n_quo     = i_dividend;
            n_divisor = i_divisor;
        end else if (r_busy) begin
            n_rem = w_qbit ? w_diff[uer_pkg::UPC_W-1:0] : w_shift[uer_pkg::UPC_W-1:0];
            n_quo = {r_quo[uer_pkg::DIVD_W-2:0], w_qbit};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_divisor <= n_divisor;
    end

    assign o_done = r_done;
    assign o_quot = (|r_quo[uer_pkg::DIVD_W-1:uer_pkg::DIST_W]) ? '1
                                                                : r_quo[uer_pkg::DIST_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/uer_chk.sv @@
`default_nettype none

`include "ultrasonic_echo_ranger_macros.svh"

module uer_chk (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic                        i_trigger_level,
    input  wire logic                        i_busy_res,
    input  wire logic                        i_done_res,
    input  wire logic [1:0]                  i_status,
    input  wire logic [uer_pkg::TICK_W-1:0]  i_echo_time_us,
    input  wire logic [uer_pkg::DIST_W-1:0]  i_distance
);

    // a tick that ends nothing carries an all-zero report
    `UER_ASSERT_IMP(a_quiet_report, i_clk, i_rst_n, i_out_valid && !i_done_res, (i_status == uer_pkg::ST_OK) && (i_echo_time_us == '0) && (i_distance == '0), "report fields set without done")

    // only a successful measurement carries a distance
    `UER_ASSERT_IMP(a_dist_only_ok, i_clk, i_rst_n, i_out_valid && (i_distance != '0), i_done_res && (i_status == uer_pkg::ST_OK), "distance on a failed report")

    // a refused start reports done with no time
    `UER_ASSERT_IMP(a_refuse_shape, i_clk, i_rst_n, i_out_valid && (i_status == uer_pkg::ST_BUSY), i_done_res && (i_echo_time_us == '0), "malformed busy refusal")

    // trigger high only inside a running measurement
    `UER_ASSERT_IMP(a_trig_busy, i_clk, i_rst_n, i_out_valid && i_trigger_level, i_busy_res, "trigger high while idle")

    // a stalled result stays offered
    `UER_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result withdrawn under stall")

endmodule

bind ultrasonic_echo_ranger uer_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_trigger_level (o_out.trigger_level),
    .i_busy_res      (o_out.busy_res),
    .i_done_res      (o_out.done_res),
    .i_status        (o_out.status),
    .i_echo_time_us  (o_out.echo_time_us),
    .i_distance      (o_out.distance)
);

`default_nettype wire
